FILE: rtl/bscf_pkg.sv
package bscf_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_CRC_POLY_LOW = 2'd0;
    localparam logic [1:0] REG_CRC_LEN      = 2'd1;
    localparam logic [1:0] REG_FLAG_PATTERN = 2'd2;

    localparam int CFG_W  = 16;
    localparam int POLY_W = 16;
    localparam int LEN_W5 = 5;
    localparam int FLAG_W = 8;
    localparam int RUN_W  = 3;

    localparam logic [POLY_W-1:0] POLY_RESET = 16'd3;
    localparam logic [LEN_W5-1:0] LEN_RESET  = 5'd3;
    localparam logic [FLAG_W-1:0] FLAG_RESET = 8'h7e;

    // per-item command, front to back
    typedef struct packed {
        logic open;      // frame opens: opening flag goes first
        logic data_bit;
        logic stuff;     // stuffed zero follows the data bit
        logic last;      // CRC and closing flag follow
    } cmd_t;

endpackage

FILE: rtl/bscf_front.sv
module bscf_front
    import bscf_pkg::*;
#(
    parameter int MAX_CRC_LEN = 16,
    parameter int STUFF_RUN   = 5,
    parameter int LEN_W       = (MAX_CRC_LEN > 1) ? $clog2(MAX_CRC_LEN) : 1
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   data_bit,
    input  logic                   frame_last,
    input  logic                   q_full,
    output logic                   in_ready,
    output logic                   push,
    output cmd_t                   push_cmd,
    output logic [MAX_CRC_LEN-1:0] push_crc,
    output logic [LEN_W-1:0]       push_len_m1,
    input  logic [POLY_W-1:0]      crc_poly_low,
    input  logic [LEN_W5-1:0]      crc_len
);

    localparam int PW = (MAX_CRC_LEN > POLY_W) ? MAX_CRC_LEN : POLY_W;

    logic                   in_frame_reg, in_frame_next;
    logic [RUN_W-1:0]       ones_reg, ones_next;
    logic [MAX_CRC_LEN-1:0] crc_reg, crc_next;

    logic [LEN_W-1:0]       len_m1;
    logic [MAX_CRC_LEN-1:0] mask;
    logic [MAX_CRC_LEN-1:0] poly_m;
    logic [PW-1:0]          poly_wide;
    logic [LEN_W5:0]        len_ext;
    logic [MAX_CRC_LEN-1:0] rem0, rem1, rem2;
    logic [RUN_W-1:0]       ones0, ones1;
    logic                   stuff;

    // one step of MSB-first long division
    function automatic logic [MAX_CRC_LEN-1:0] feed(
        input logic [MAX_CRC_LEN-1:0] rem,
        input logic                   b,
        input logic [LEN_W-1:0]       top_idx,
        input logic [MAX_CRC_LEN-1:0] msk,
        input logic [MAX_CRC_LEN-1:0] pl
    );
        logic [MAX_CRC_LEN-1:0] r;
        logic                   fb;
        fb = rem[top_idx] ^ b;
        r  = (rem << 1) & msk;
        if (fb)
        begin
            r = r ^ (pl & msk);
        end
        return r;
    endfunction

    always_comb
    begin
        len_ext = {1'b0, crc_len};
        if (crc_len == '0)
        begin
            len_m1 = '0;
        end
        else if (len_ext > (LEN_W5+1)'(MAX_CRC_LEN))
        begin
            len_m1 = LEN_W'(MAX_CRC_LEN - 1);
        end
        else
        begin
            len_m1 = LEN_W'(len_ext - 1'b1);
        end
        for (int i = 0; i < MAX_CRC_LEN; i++)
        begin
            mask[i] = ((LEN_W+1)'(i) <= {1'b0, len_m1});
        end
    end

    assign poly_wide = PW'(crc_poly_low);
    assign poly_m    = poly_wide[MAX_CRC_LEN-1:0];

    assign rem0  = in_frame_reg ? crc_reg : '0;
    assign ones0 = in_frame_reg ? ones_reg : '0;
    assign rem1  = feed(rem0, data_bit, len_m1, mask, poly_m);
    assign ones1 = data_bit ? RUN_W'(ones0 + 1'b1) : '0;
    assign stuff = (ones1 >= RUN_W'(STUFF_RUN));
    assign rem2  = stuff ? feed(rem1, 1'b0, len_m1, mask, poly_m) : rem1;

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    assign push_cmd.open     = !in_frame_reg;
    assign push_cmd.data_bit = data_bit;
    assign push_cmd.stuff    = stuff;
    assign push_cmd.last     = frame_last;
    assign push_crc          = rem2;
    assign push_len_m1       = len_m1;

    always_comb
    begin
        in_frame_next = in_frame_reg;
        ones_next     = ones_reg;
        crc_next      = crc_reg;
        if (push)
        begin
            if (frame_last)
            begin
                in_frame_next = 1'b0;
                ones_next     = '0;
                crc_next      = '0;
            end
            else
            begin
                in_frame_next = 1'b1;
                ones_next     = stuff ? '0 : ones1;
                crc_next      = rem2;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            ones_reg     <= '0;
            crc_reg      <= '0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            ones_reg     <= ones_next;
            crc_reg      <= crc_next;
        end
    end

endmodule

FILE: rtl/bscf_queue.sv
module bscf_queue
    import bscf_pkg::*;
#(
    parameter int W = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] wdata,
    input  logic         pop,
    output logic [W-1:0] rdata,
    output logic         not_empty,
    output logic         full
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    logic [W-1:0]     mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;

    assign rdata     = mem_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == (PTR_W+1)'(DEPTH));

    always_comb
    begin
        wr_ptr_next = push ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop  ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: rtl/bscf_back.sv
module bscf_back
    import bscf_pkg::*;
#(
    parameter int MAX_CRC_LEN = 16,
    parameter int LEN_W       = (MAX_CRC_LEN > 1) ? $clog2(MAX_CRC_LEN) : 1
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    input  cmd_t                   q_cmd,
    input  logic [MAX_CRC_LEN-1:0] q_crc,
    input  logic [LEN_W-1:0]       q_len_m1,
    output logic                   q_pop,
    input  logic [FLAG_W-1:0]      flag_pattern,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   line_bit,
    output logic                   run_last,
    output logic                   frame_done
);

    localparam int CNT_W = (LEN_W > 3) ? LEN_W : 3;

    typedef enum logic [5:0] {
        P_IDLE  = 6'b000001,
        P_OPEN  = 6'b000010,
        P_DATA  = 6'b000100,
        P_STUFF = 6'b001000,
        P_CRC   = 6'b010000,
        P_CLOSE = 6'b100000
    } phase_t;

    phase_t                 phase_reg, phase_next, adv_phase;
    logic [CNT_W-1:0]       cnt_reg, cnt_next, adv_cnt;
    cmd_t                   cur_cmd_reg;
    logic [MAX_CRC_LEN-1:0] cur_crc_reg;
    logic [LEN_W-1:0]       cur_len_reg;
    logic                   out_valid_reg, out_valid_next;
    logic                   bit_reg, last_reg, done_reg;

    logic emit_bit, emit_last, emit_done, fin;
    logic can_load, step, load;

    always_comb
    begin
        emit_bit  = 1'b0;
        emit_last = 1'b0;
        emit_done = 1'b0;
        fin       = 1'b0;
        adv_phase = phase_reg;
        adv_cnt   = cnt_reg;
        case (phase_reg)
            P_OPEN:
            begin
                emit_bit = flag_pattern[cnt_reg[2:0]];
                if (cnt_reg == '0)
                begin
                    adv_phase = P_DATA;
                end
                else
                begin
                    adv_cnt = cnt_reg - 1'b1;
                end
            end
            P_DATA:
            begin
                emit_bit = cur_cmd_reg.data_bit;
                if (cur_cmd_reg.stuff)
                begin
                    adv_phase = P_STUFF;
                end
                else if (cur_cmd_reg.last)
                begin
                    adv_phase = P_CRC;
                    adv_cnt   = CNT_W'(cur_len_reg);
                end
                else
                begin
                    fin       = 1'b1;
                    emit_last = 1'b1;
                end
            end
            P_STUFF:
            begin
                emit_bit = 1'b0;
                if (cur_cmd_reg.last)
                begin
                    adv_phase = P_CRC;
                    adv_cnt   = CNT_W'(cur_len_reg);
                end
                else
                begin
                    fin       = 1'b1;
                    emit_last = 1'b1;
                end
            end
            P_CRC:
            begin
                emit_bit = cur_crc_reg[cnt_reg[LEN_W-1:0]];
                if (cnt_reg == '0)
                begin
                    adv_phase = P_CLOSE;
                    adv_cnt   = CNT_W'(FLAG_W - 1);
                end
                else
                begin
                    adv_cnt = cnt_reg - 1'b1;
                end
            end
            P_CLOSE:
            begin
                emit_bit = flag_pattern[cnt_reg[2:0]];
                if (cnt_reg == '0)
                begin
                    fin       = 1'b1;
                    emit_last = 1'b1;
                    emit_done = 1'b1;
                end
                else
                begin
                    adv_cnt = cnt_reg - 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign can_load = !out_valid_reg || out_ready;
    assign step     = can_load && (phase_reg != P_IDLE);
    // next command enters while the current one sends its final bit
    assign load     = q_valid && ((phase_reg == P_IDLE) || (step && fin));
    assign q_pop    = load;

    always_comb
    begin
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            phase_next = q_cmd.open ? P_OPEN : P_DATA;
            cnt_next   = CNT_W'(FLAG_W - 1);
        end
        else if (step)
        begin
            phase_next = fin ? P_IDLE : adv_phase;
            cnt_next   = adv_cnt;
        end
        if (can_load)
        begin
            out_valid_next = step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= P_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cur_cmd_reg <= q_cmd;
            cur_crc_reg <= q_crc;
            cur_len_reg <= q_len_m1;
        end
        if (step)
        begin
            bit_reg  <= emit_bit;
            last_reg <= emit_last;
            done_reg <= emit_done;
        end
    end

    assign out_valid  = out_valid_reg;
    assign line_bit   = bit_reg;
    assign run_last   = last_reg;
    assign frame_done = done_reg;

endmodule

FILE: rtl/bit_stuff_crc_framer.sv
// Bit-stuffing framer with CRC.
// Input stream (s_*): one payload bit per word, s_tdata[0] = data_bit,
// s_tlast marks the final payload bit of a frame.
// Output stream (m_*): one line bit per word, m_tdata[0] = line_bit,
// m_tlast ends the run of bits caused by one input word, m_tuser marks
// the last bit of the closing flag.
// A frame starts with the flag byte (MSB first); a zero is stuffed after
// STUFF_RUN ones; on the last bit the CRC (MSB first, unstuffed) and the
// closing flag follow.
// Config: cfg_we / cfg_index / cfg_wdata; the user must write them only
// while idle, the block does not enforce it. A word passes the command
// queue and the back sequencer into the output register. Throughput:
// the back sends one line bit per cycle unless m_tready stalls it; a
// word causes 1 to 8+2+MAX_CRC_LEN+8 line bits. The front takes one
// word per cycle until its 4-entry command queue fills.
// Reset: no frame open, queue empty, registers back to poly 3, length 3,
// flag 0x7e. A stall on m_tready holds the output word; the queue keeps
// taking input words until full, then s_tready drops.
module bit_stuff_crc_framer
    import bscf_pkg::*;
#(
    parameter int MAX_CRC_LEN = 16,
    parameter int STUFF_RUN   = 5
)
(
    input  logic             clk,
    input  logic             rst_n,
    // stream in
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // [0] data_bit, [7:1] zero
    input  logic             s_tlast,   // frame_last
    // stream out
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,   // [0] line_bit, [7:1] zero
    output logic             m_tlast,   // run_last
    output logic             m_tuser,   // [0] frame_done
    // config write port
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata
);

    localparam int LEN_W = (MAX_CRC_LEN > 1) ? $clog2(MAX_CRC_LEN) : 1;
    localparam int CMD_W = $bits(cmd_t);
    localparam int Q_W   = CMD_W + MAX_CRC_LEN + LEN_W;

    // config registers
    logic [POLY_W-1:0] poly_reg;
    logic [LEN_W5-1:0] len_reg;
    logic [FLAG_W-1:0] flag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg <= POLY_RESET;
            len_reg  <= LEN_RESET;
            flag_reg <= FLAG_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CRC_POLY_LOW: poly_reg <= cfg_wdata[POLY_W-1:0];
                REG_CRC_LEN:      len_reg  <= cfg_wdata[LEN_W5-1:0];
                REG_FLAG_PATTERN: flag_reg <= cfg_wdata[FLAG_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // front: stuffing decision and CRC update per input word
    logic                   push, q_full, q_valid, q_pop;
    cmd_t                   push_cmd, q_cmd;
    logic [MAX_CRC_LEN-1:0] push_crc, q_crc;
    logic [LEN_W-1:0]       push_len_m1, q_len_m1;
    logic [Q_W-1:0]         q_wdata, q_rdata;

    bscf_front #(
        .MAX_CRC_LEN (MAX_CRC_LEN),
        .STUFF_RUN   (STUFF_RUN),
        .LEN_W       (LEN_W)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .data_bit     (s_tdata[0]),
        .frame_last   (s_tlast),
        .q_full       (q_full),
        .in_ready     (s_tready),
        .push         (push),
        .push_cmd     (push_cmd),
        .push_crc     (push_crc),
        .push_len_m1  (push_len_m1),
        .crc_poly_low (poly_reg),
        .crc_len      (len_reg)
    );

    assign q_wdata = {push_len_m1, push_crc, push_cmd};

    bscf_queue #(
        .W (Q_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wdata     (q_wdata),
        .pop       (q_pop),
        .rdata     (q_rdata),
        .not_empty (q_valid),
        .full      (q_full)
    );

    assign q_cmd    = q_rdata[CMD_W-1:0];
    assign q_crc    = q_rdata[CMD_W +: MAX_CRC_LEN];
    assign q_len_m1 = q_rdata[CMD_W+MAX_CRC_LEN +: LEN_W];

    // back: bit sequencer into the output register
    logic line_bit;

    bscf_back #(
        .MAX_CRC_LEN (MAX_CRC_LEN),
        .LEN_W       (LEN_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_cmd        (q_cmd),
        .q_crc        (q_crc),
        .q_len_m1     (q_len_m1),
        .q_pop        (q_pop),
        .flag_pattern (flag_reg),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .line_bit     (line_bit),
        .run_last     (m_tlast),
        .frame_done   (m_tuser)
    );

    assign m_tdata = {7'b0, line_bit};

    // closing flag bit always ends the run of its word
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("frame_done without run_last");

    // back never pops an empty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    // front never pushes into a full queue
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!q_full && s_tready))
        else $error("queue pushed while full");

endmodule
